// ===== sv/assert_macros.svh =====
// Assertion macros shared by the waveform generator RTL.
// Standalone header: no dependencies, included by the modules that check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/twg_pkg.sv =====
// Types, register indexes and constant tables for the two-channel
// waveform generator. No dependencies.
package twg_pkg;

  localparam int DIVIDER_BITS = 16;
  localparam int CFG_DATA_BITS = DIVIDER_BITS;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [1:0] {
    MODE_SQUARE   = 2'd0,
    MODE_SAWTOOTH = 2'd1,
    MODE_SINE     = 2'd2
  } mode_t;

  // Per-channel configuration handed from the register file to a channel.
  typedef struct packed {
    mode_t                   mode;
    logic [DIVIDER_BITS-1:0] divider;
    logic [2:0]              amplitude;
  } chan_cfg_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_MODE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_MODE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_DIVIDER   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_DIVIDER   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH1_AMPLITUDE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CH2_AMPLITUDE = 3'd5;

  // Level and angle arithmetic.
  localparam logic [8:0] LEVEL_STEP = 9'd51;
  localparam logic [8:0] ANGLE_STEP = 9'd7;
  localparam logic [8:0] ANGLE_HALF = 9'd180;
  localparam logic [8:0] ANGLE_WRAP = 9'd360;

  // Integer approximation of 50*sin(a) for a = 0..179 degrees (non-negative half).
  localparam logic [5:0] SINE_POS [0:179] = '{
     0,  0,  1,  2,  3,  4,  5,  6,  6,  7,
     8,  9, 10, 11, 12, 12, 13, 14, 15, 16,
    17, 17, 18, 19, 20, 21, 21, 22, 23, 24,
    24, 25, 26, 27, 27, 28, 29, 30, 30, 31,
    32, 32, 33, 34, 34, 35, 35, 36, 37, 37,
    38, 38, 39, 39, 40, 40, 41, 41, 42, 42,
    43, 43, 44, 44, 44, 45, 45, 46, 46, 46,
    46, 47, 47, 47, 48, 48, 48, 48, 48, 49,
    49, 49, 49, 49, 49, 49, 49, 49, 49, 49,
    49, 49, 49, 49, 49, 49, 49, 49, 49, 49,
    49, 49, 48, 48, 48, 48, 48, 47, 47, 47,
    46, 46, 46, 46, 45, 45, 44, 44, 44, 43,
    43, 42, 42, 41, 41, 40, 40, 39, 39, 38,
    38, 37, 37, 36, 35, 35, 34, 34, 33, 32,
    32, 31, 30, 30, 29, 28, 27, 27, 26, 25,
    25, 24, 23, 22, 21, 21, 20, 19, 18, 17,
    17, 16, 15, 14, 13, 12, 12, 11, 10,  9,
     8,  7,  6,  6,  5,  4,  3,  2,  1,  0
  };

  // Integer approximation of the magnitude of 50*sin(a) for a = 180..359, indexed by a - 180.
  localparam logic [5:0] SINE_NEG [0:179] = '{
     0,  0,  1,  2,  3,  4,  5,  6,  6,  7,
     8,  9, 10, 11, 12, 12, 13, 14, 15, 16,
    17, 17, 18, 19, 20, 21, 21, 22, 23, 24,
    24, 25, 26, 27, 27, 28, 29, 30, 30, 31,
    32, 32, 33, 34, 34, 35, 35, 36, 37, 37,
    38, 38, 39, 39, 40, 40, 41, 41, 42, 42,
    43, 43, 44, 44, 44, 45, 45, 46, 46, 46,
    46, 47, 47, 47, 48, 48, 48, 48, 48, 49,
    49, 49, 49, 49, 49, 49, 49, 49, 49, 49,
    49, 49, 49, 49, 49, 49, 49, 49, 49, 49,
    49, 49, 48, 48, 48, 48, 48, 47, 47, 47,
    47, 46, 46, 46, 45, 45, 44, 44, 44, 43,
    43, 42, 42, 41, 41, 40, 40, 39, 39, 38,
    38, 37, 37, 36, 36, 35, 34, 34, 33, 32,
    32, 31, 30, 30, 29, 28, 28, 27, 26, 25,
    25, 24, 23, 22, 21, 21, 20, 19, 18, 17,
    17, 16, 15, 14, 13, 12, 12, 11, 10,  9,
     8,  7,  7,  6,  5,  4,  3,  2,  1,  0
  };

endpackage

// ===== sv/twg_chan.sv =====
// One waveform channel: tick divider, level register and sine angle.
// Depends on twg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twg_chan (
  input  logic              clk,
  input  logic              rst,
  input  twg_pkg::chan_cfg_t cfg,
  input  logic              tick,
  output logic [7:0]        level
);

  logic [twg_pkg::DIVIDER_BITS-1:0] tick_count;
  logic [twg_pkg::DIVIDER_BITS-1:0] tick_count_next;
  logic [twg_pkg::DIVIDER_BITS-1:0] div_eff;
  logic [twg_pkg::DIVIDER_BITS-1:0] count_inc;
  logic [8:0]                       angle;
  logic [8:0]                       angle_next;
  logic [8:0]                       angle_inc;
  logic [8:0]                       amp_x51;
  logic [7:0]                       half_amp;
  logic [7:0]                       neg_idx;
  logic [7:0]                       sine_level;
  logic [7:0]                       level_next;
  logic                             fire;

  // Divider: update on count zero, wrap to zero once the incremented count reaches the divider (zero acts as one)
  always_comb begin
    div_eff         = (cfg.divider == '0) ? twg_pkg::DIVIDER_BITS'(1) : cfg.divider;
    fire            = (tick_count == '0);
    count_inc       = tick_count + twg_pkg::DIVIDER_BITS'(1);
    tick_count_next = (count_inc >= div_eff) ? '0 : count_inc;
  end

  // Amplitude scaling and sine lookup from the two half-wave tables
  always_comb begin
    amp_x51  = 9'(cfg.amplitude) * twg_pkg::LEVEL_STEP;
    half_amp = amp_x51[8:1];
    neg_idx  = 8'(angle - twg_pkg::ANGLE_HALF);
    if (angle < twg_pkg::ANGLE_HALF) begin
      sine_level = half_amp - {2'b00, twg_pkg::SINE_POS[angle[7:0]]};
    end else begin
      sine_level = half_amp + {2'b00, twg_pkg::SINE_NEG[neg_idx]};
    end
    angle_inc = angle + twg_pkg::ANGLE_STEP;
    if (angle_inc >= twg_pkg::ANGLE_WRAP) begin
      angle_inc = angle_inc - twg_pkg::ANGLE_WRAP;
    end
  end

  // Select the next level by mode; an unused mode code holds the level
  always_comb begin
    level_next = level;
    angle_next = angle;
    if (fire) begin
      case (cfg.mode)
        twg_pkg::MODE_SQUARE: begin
          level_next = (level == '0) ? amp_x51[7:0] : '0;
        end
        twg_pkg::MODE_SAWTOOTH: begin
          level_next = level + 8'd1;
        end
        twg_pkg::MODE_SINE: begin
          level_next = sine_level;
          angle_next = angle_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance channel state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      level      <= '0;
      angle      <= '0;
    end else if (tick) begin
      tick_count <= tick_count_next;
      level      <= level_next;
      angle      <= angle_next;
    end
  end

  `ASSERT_IMPLY(a_angle_range, clk, rst, 1'b1, angle < twg_pkg::ANGLE_WRAP, "angle out of range")
  `ASSERT_NEXT(a_hold_no_tick, clk, rst, !tick, $stable(level) && $stable(angle) && $stable(tick_count), "state moved without tick")
  `ASSERT_NEXT(a_angle_sine_only, clk, rst, tick && !(fire && cfg.mode == twg_pkg::MODE_SINE), $stable(angle), "angle moved outside sine update")
  `ASSERT_NEXT(a_ramp_step, clk, rst, tick && fire && cfg.mode == twg_pkg::MODE_SAWTOOTH, level == $past(level) + 8'd1, "ramp did not step by one")

endmodule

// ===== sv/two_channel_waveform_generator_top.sv =====
// Top level of the two-channel waveform generator: configuration registers,
// handshake and result register. Depends on twg_pkg, twg_chan, assert_macros.svh.
//
//   channel  signals                                   payload
//   cfg      cfg_valid / cfg_ready                     cfg_index, cfg_data
//   in       in_valid / in_ready                       advance
//   out      out_valid / out_ready                     ch1_level, ch2_level
//
// One tick per clock cycle while in_ready is high and advance is set: each transaction is handled in the
// cycle it is accepted and its result shows in the next cycle from the channel level registers.
// The rate is set by the single result register, which can refill as it drains.
// in_ready drops only while a result is pending and out_ready is low.
// Synchronous active-high reset; cfg_ready is always high.
`include "assert_macros.svh"

module two_channel_waveform_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [twg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                advance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          ch1_level,
  output logic [7:0]                          ch2_level
);

  twg_pkg::chan_cfg_t ch1_cfg;
  twg_pkg::chan_cfg_t ch2_cfg;
  logic               in_accept;
  logic               tick;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign tick      = in_accept && advance;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      ch1_cfg.mode      <= twg_pkg::MODE_SQUARE;
      ch2_cfg.mode      <= twg_pkg::MODE_SAWTOOTH;
      ch1_cfg.divider   <= twg_pkg::DIVIDER_BITS'(1);
      ch2_cfg.divider   <= twg_pkg::DIVIDER_BITS'(1);
      ch1_cfg.amplitude <= 3'd2;
      ch2_cfg.amplitude <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twg_pkg::REG_CH1_MODE:      ch1_cfg.mode      <= twg_pkg::mode_t'(cfg_data[1:0]);
        twg_pkg::REG_CH2_MODE:      ch2_cfg.mode      <= twg_pkg::mode_t'(cfg_data[1:0]);
        twg_pkg::REG_CH1_DIVIDER:   ch1_cfg.divider   <= cfg_data;
        twg_pkg::REG_CH2_DIVIDER:   ch2_cfg.divider   <= cfg_data;
        twg_pkg::REG_CH1_AMPLITUDE: ch1_cfg.amplitude <= cfg_data[2:0];
        twg_pkg::REG_CH2_AMPLITUDE: ch2_cfg.amplitude <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Result valid: set on each transaction, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  twg_chan u_ch1 (
    .clk   (clk),
    .rst   (rst),
    .cfg   (ch1_cfg),
    .tick  (tick),
    .level (ch1_level)
  );

  twg_chan u_ch2 (
    .clk   (clk),
    .rst   (rst),
    .cfg   (ch2_cfg),
    .tick  (tick),
    .level (ch2_level)
  );

  `ASSERT_NEXT(a_accept_gives_result, clk, rst, in_accept, out_valid, "accepted item produced no result")
  `ASSERT_IMPLY(a_empty_is_ready, clk, rst, !out_valid, in_ready, "input stalled with empty result slot")
  `ASSERT_NEXT(a_hold_keeps_levels, clk, rst, in_accept && !advance, $stable(ch1_level) && $stable(ch2_level), "hold item changed a level")

endmodule
